// File: src/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
package lkvc_pkg;

	localparam int DEFAULT_ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VALUE_W = 32;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

	typedef struct packed {
		logic mode;
		logic signed [KEY_W-1:0] key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic hit;
		logic evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

	typedef struct packed {
		logic write;
		logic hit;
		logic evict;
		logic occupied;
		logic at_fill;
		logic at_last;
	} cell_ctl_t;

endpackage

// File: src/lru_key_value_cache.sv
// top level of the lru key-value cache: input register, cell chain, result register
// a request waits in the input register and moves into the result register once that is empty or rsp is not stalled
// throughput: one transaction per cycle while rsp is not stalled; all cells compare
// and the stack shifts in the same cycle of the cell chain
// reset: occupancy cleared, capacity set to 16, no valid transactions in flight;
// cell contents are left undefined and are never read before being written
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              capacity_we,
	input  logic [lkvc_pkg::CFG_W-1:0]        capacity_wdata,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  lkvc_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output lkvc_pkg::rsp_t                    rsp
);

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW = (OCC_W > lkvc_pkg::CFG_W) ? OCC_W : lkvc_pkg::CFG_W;

	logic [lkvc_pkg::CFG_W-1:0] capacity_q;
	logic [OCC_W-1:0]           occ_q;
	logic                       valid_s1_q;
	lkvc_pkg::req_t             req_s1_q;
	logic                       rsp_valid_q;
	lkvc_pkg::rsp_t             rsp_q;

	logic                       advance;
	logic                       is_set;
	logic                       hit;
	logic                       evict_cond;
	logic [CW-1:0]              cap_ext;
	logic [CW-1:0]              eff_cap;
	logic [lkvc_pkg::VALUE_W-1:0] read_or;
	logic [lkvc_pkg::KEY_W-1:0]   last_or;

	lkvc_pkg::cell_ctl_t          ctl_w    [ENTRIES];
	logic [lkvc_pkg::KEY_W-1:0]   key_w    [ENTRIES];
	logic [lkvc_pkg::VALUE_W-1:0] value_w  [ENTRIES];
	logic [lkvc_pkg::VALUE_W-1:0] tapv_w   [ENTRIES];
	logic [lkvc_pkg::KEY_W-1:0]   tapk_w   [ENTRIES];
	logic [ENTRIES-1:0]           match_w;
	logic [ENTRIES:0]             chain_w;

	assign advance   = valid_s1_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1_q && !advance;
	assign is_set    = (req_s1_q.mode == lkvc_pkg::MODE_SET);
	assign hit       = |match_w;

	assign cap_ext = CW'(capacity_q);
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign evict_cond = (occ_q != '0) && (CW'(occ_q) >= eff_cap);

	assign chain_w[ENTRIES] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		always_comb begin
			ctl_w[i].write    = advance && is_set;
			ctl_w[i].hit      = hit;
			ctl_w[i].evict    = evict_cond;
			ctl_w[i].occupied = (OCC_W'(i) < occ_q);
			ctl_w[i].at_fill  = (OCC_W'(i) == occ_q);
			ctl_w[i].at_last  = (OCC_W'(i + 1) == occ_q);
		end

		lkvc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl_w[i]),
			.cmp_key    (req_s1_q.key),
			.prev_key   ((i == 0) ? req_s1_q.key : key_w[(i == 0) ? 0 : i - 1]),
			.prev_value ((i == 0) ? req_s1_q.value : value_w[(i == 0) ? 0 : i - 1]),
			.below      (chain_w[i + 1]),
			.key        (key_w[i]),
			.value      (value_w[i]),
			.match      (match_w[i]),
			.chain      (chain_w[i]),
			.tap_value  (tapv_w[i]),
			.tap_key    (tapk_w[i])
		);
	end

	always_comb begin
		read_or = '0;
		last_or = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			read_or = read_or | tapv_w[i];
			last_or = last_or | tapk_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAPACITY_RESET;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1_q <= 1'b1;
		end else if (advance) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (advance && is_set && !hit && !evict_cond) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.hit <= hit;
			if (is_set) begin
				rsp_q.read_value  <= '0;
				rsp_q.evicted     <= !hit && evict_cond;
				rsp_q.evicted_key <= (!hit && evict_cond) ? last_or : '0;
			end else begin
				rsp_q.read_value  <= hit ? read_or : lkvc_pkg::MISS_VALUE;
				rsp_q.evicted     <= 1'b0;
				rsp_q.evicted_key <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above entry count");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q |-> $onehot0(match_w))
		else $error("key present in more than one cell");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("processed transaction produced no response");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.evicted && rsp_q.hit))
		else $error("eviction reported on a hit");

endmodule

// File: src/lkvc_cell.sv
// one stack cell: holds an entry, compares it and shifts from its upper neighbor
module lkvc_cell (
	input  logic                                clk,
	input  lkvc_pkg::cell_ctl_t                 ctl,
	input  logic [lkvc_pkg::KEY_W-1:0]          cmp_key,
	input  logic [lkvc_pkg::KEY_W-1:0]          prev_key,
	input  logic [lkvc_pkg::VALUE_W-1:0]        prev_value,
	input  logic                                below,
	output logic [lkvc_pkg::KEY_W-1:0]          key,
	output logic [lkvc_pkg::VALUE_W-1:0]        value,
	output logic                                match,
	output logic                                chain,
	output logic [lkvc_pkg::VALUE_W-1:0]        tap_value,
	output logic [lkvc_pkg::KEY_W-1:0]          tap_key
);

	logic [lkvc_pkg::KEY_W-1:0]   key_q;
	logic [lkvc_pkg::VALUE_W-1:0] value_q;
	logic                         shift;

	assign match = ctl.occupied && (key_q == cmp_key);
	assign chain = match || below;

	// hit: entries from the top down to the match move; miss: fill region moves
	assign shift = ctl.write &&
		(ctl.hit ? chain : (ctl.occupied || (ctl.at_fill && !ctl.evict)));

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key       = key_q;
	assign value     = value_q;
	assign tap_value = match ? value_q : '0;
	assign tap_key   = ctl.at_last ? key_q : '0;

endmodule
